FILE: design/atoe_pkg.sv
// types, sizes and codes shared by the associative table with oldest-entry eviction
`default_nettype none
package atoe_pkg;

   localparam int TABLE_ENTRIES = 8;
   localparam int KEY_BITS      = 64;
   localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);
   localparam int STAMP_BITS    = 32;

   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TABLE_ENTRIES - 1);

   localparam logic [1:0] OP_SET   = 2'd0;
   localparam logic [1:0] OP_FIND  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_SCAN,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] key_tag;
      logic [31:0] buffer_handle;
      logic [31:0] buffer_size;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [2:0]  slot;
      logic        evicted;
      logic [31:0] found_handle;
      logic [31:0] found_size;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic look;
      logic scan;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_done;
   } sts_type;

endpackage
`default_nettype wire

FILE: design/atoe_ctrl.sv
// controller state machine: lookup, optional oldest-entry scan, execute
`default_nettype none
module atoe_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire atoe_pkg::sts_type sts,
   output atoe_pkg::cmd_type      cmd,
   output logic                   busy
);

   atoe_pkg::state_type state_ff;
   atoe_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= atoe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         atoe_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = atoe_pkg::ST_LOOK;
            end
         end
         atoe_pkg::ST_LOOK: begin
            cmd.look = 1'b1;
            state_in = sts.need_scan ? atoe_pkg::ST_SCAN : atoe_pkg::ST_EXEC;
         end
         atoe_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = atoe_pkg::ST_EXEC;
            end
         end
         atoe_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = atoe_pkg::ST_IDLE;
         end
         default: begin
            state_in = atoe_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != atoe_pkg::ST_IDLE);

endmodule
`default_nettype wire

FILE: design/atoe_dpath.sv
// datapath: entry registers, parallel key compare, serial stamp scan, result register
`default_nettype none
module atoe_dpath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire atoe_pkg::cmd_type cmd,
   input  wire atoe_pkg::req_type req_data,
   output atoe_pkg::sts_type      sts,
   output logic                   rsp_valid,
   output atoe_pkg::rsp_type      rsp_data
);

   localparam int N  = atoe_pkg::TABLE_ENTRIES;
   localparam int SB = atoe_pkg::SLOT_BITS;

   atoe_pkg::req_type req_ff, req_in;

   logic [atoe_pkg::KEY_BITS-1:0]   key_ff    [N];
   logic [atoe_pkg::KEY_BITS-1:0]   key_in    [N];
   logic [31:0]                     handle_ff [N];
   logic [31:0]                     handle_in [N];
   logic [31:0]                     length_ff [N];
   logic [31:0]                     length_in [N];
   logic [atoe_pkg::STAMP_BITS-1:0] stamp_ff  [N];
   logic [atoe_pkg::STAMP_BITS-1:0] stamp_in  [N];
   logic [N-1:0]                    valid_ff, valid_in;
   logic [atoe_pkg::STAMP_BITS-1:0] counter_ff, counter_in;

   logic                            hit_ff, hit_in;
   logic [SB-1:0]                   hit_idx_ff, hit_idx_in;
   logic                            free_ff, free_in;
   logic [SB-1:0]                   free_idx_ff, free_idx_in;
   logic [SB-1:0]                   scan_idx_ff, scan_idx_in;
   logic [SB-1:0]                   best_idx_ff, best_idx_in;
   logic [atoe_pkg::STAMP_BITS-1:0] best_stamp_ff, best_stamp_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   atoe_pkg::rsp_type               rsp_ff, rsp_in;

   logic [N-1:0]                    match_vec;
   logic                            hit_any, free_any;
   logic [SB-1:0]                   hit_pos, free_pos;
   logic [SB-1:0]                   target;
   logic [SB+2:0]                   slot_wide;
   logic [SB+2:0]                   hit_wide;

   // parallel compare and lowest-index pick
   always_comb begin
      hit_pos  = '0;
      free_pos = '0;
      for (int i = 0; i < N; i++) begin
         match_vec[i] = valid_ff[i] &&
                        (key_ff[i] == req_ff.key_tag[atoe_pkg::KEY_BITS-1:0]);
      end
      for (int i = N - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            hit_pos = SB'(i);
         end
         if (!valid_ff[i]) begin
            free_pos = SB'(i);
         end
      end
      hit_any  = |match_vec;
      free_any = ~&valid_ff;
   end

   assign sts.need_scan = (req_ff.opcode == atoe_pkg::OP_SET) && !hit_any && !free_any;
   assign sts.scan_done = (scan_idx_ff == atoe_pkg::LAST_SLOT);

   assign target    = hit_ff ? hit_idx_ff : (free_ff ? free_idx_ff : best_idx_ff);
   assign slot_wide = {3'b000, target};
   assign hit_wide  = {3'b000, hit_idx_ff};

   always_comb begin
      req_in        = cmd.load ? req_data : req_ff;
      key_in        = key_ff;
      handle_in     = handle_ff;
      length_in     = length_ff;
      stamp_in      = stamp_ff;
      valid_in      = valid_ff;
      counter_in    = counter_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      scan_idx_in   = scan_idx_ff;
      best_idx_in   = best_idx_ff;
      best_stamp_in = best_stamp_ff;
      rsp_valid_in  = cmd.exec;
      rsp_in        = rsp_ff;

      if (cmd.look) begin
         hit_in        = hit_any;
         hit_idx_in    = hit_pos;
         free_in       = free_any;
         free_idx_in   = free_pos;
         scan_idx_in   = SB'(1);
         best_idx_in   = '0;
         best_stamp_in = stamp_ff[0];
      end

      // one stamp per beat, strict less keeps the lowest index on a tie
      if (cmd.scan) begin
         scan_idx_in = scan_idx_ff + SB'(1);
         if (stamp_ff[scan_idx_ff] < best_stamp_ff) begin
            best_idx_in   = scan_idx_ff;
            best_stamp_in = stamp_ff[scan_idx_ff];
         end
      end

      if (cmd.exec) begin
         rsp_in = '0;
         unique case (req_ff.opcode)
            atoe_pkg::OP_SET: begin
               handle_in[target] = req_ff.buffer_handle;
               length_in[target] = req_ff.buffer_size;
               stamp_in[target]  = counter_ff;
               counter_in        = counter_ff + 32'd1;
               if (!hit_ff) begin
                  key_in[target]   = req_ff.key_tag[atoe_pkg::KEY_BITS-1:0];
                  valid_in[target] = 1'b1;
               end
               rsp_in.found   = hit_ff;
               rsp_in.slot    = slot_wide[2:0];
               rsp_in.evicted = !hit_ff && !free_ff;
            end
            atoe_pkg::OP_FIND: begin
               if (hit_ff) begin
                  rsp_in.found        = 1'b1;
                  rsp_in.slot         = hit_wide[2:0];
                  rsp_in.found_handle = handle_ff[hit_idx_ff];
                  rsp_in.found_size   = length_ff[hit_idx_ff];
               end
            end
            atoe_pkg::OP_CLEAR: begin
               if (hit_ff) begin
                  rsp_in.found         = 1'b1;
                  rsp_in.slot          = hit_wide[2:0];
                  valid_in[hit_idx_ff] = 1'b0;
               end
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      key_ff        <= key_in;
      handle_ff     <= handle_in;
      length_ff     <= length_in;
      stamp_ff      <= stamp_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      scan_idx_ff   <= scan_idx_in;
      best_idx_ff   <= best_idx_in;
      best_stamp_ff <= best_stamp_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

FILE: design/assoc_table_oldest_evict_unit.sv
// top level of the associative table with oldest-entry eviction
//
//   channel   ports                          beat taken when
//   request   start, busy, req_data          start high and busy low
//   response  rsp_valid, rsp_data            rsp_valid high (one cycle)
//
// lookup then execute: the accepted request passes the lookup and execute states, and
// execute loads the result register; the next beat can be taken in the strobe cycle
// a set that misses on a full table first runs a serial stamp scan for the oldest entry
// busy stays high until the cycle in which the result strobes
// synchronous reset clears all valid bits and the stamp counter at once
// results are never held off; each strobe lasts exactly one cycle
`default_nettype none
module assoc_table_oldest_evict_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire atoe_pkg::req_type req_data,
   output logic                   rsp_valid,
   output atoe_pkg::rsp_type      rsp_data
);

   atoe_pkg::cmd_type cmd;
   atoe_pkg::sts_type sts;

   atoe_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   atoe_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

FILE: design/atoe_checker.sv
// port-level checks for the associative table, bound to the top level
`default_nettype none
module atoe_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire atoe_pkg::rsp_type rsp_data
);

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_done_with_result: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_evict_is_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.evicted) |-> !rsp_data.found)
      else $error("eviction reported together with a hit");

   a_data_needs_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_data.found_handle != 32'd0) || (rsp_data.found_size != 32'd0)))
         |-> rsp_data.found)
      else $error("stored data returned without a hit");

endmodule

bind assoc_table_oldest_evict_unit atoe_checker u_atoe_checker (.*);
`default_nettype wire

FILE: verif/assoc_table_oldest_evict_unit_test.sv
// self-checking testbench for the associative table with oldest-entry eviction
`timescale 1ns / 100ps
module assoc_table_oldest_evict_unit_test;

   localparam logic [1:0]        OP_NONE      = 2'd3;
   localparam int                QUIET_LIMIT  = 500;
   localparam int                RANDOM_BEATS = 1500;
   localparam int                CALM_FROM    = 1300;
   localparam atoe_pkg::rsp_type NO_HIT       = '0;

   typedef struct {
      atoe_pkg::req_type beat;
      bit                pinned;
      atoe_pkg::rsp_type want;
   } stim_row_type;

   logic              clock;
   logic              reset    = 1'b1;
   logic              start    = 1'b0;
   atoe_pkg::req_type req_data = '0;
   logic              busy;
   logic              rsp_valid;
   atoe_pkg::rsp_type rsp_data;

   logic [atoe_pkg::KEY_BITS-1:0] stored_key    [atoe_pkg::TABLE_ENTRIES];
   logic [31:0]                   stored_handle [atoe_pkg::TABLE_ENTRIES];
   logic [31:0]                   stored_size   [atoe_pkg::TABLE_ENTRIES];
   logic [31:0]                   entry_age     [atoe_pkg::TABLE_ENTRIES];
   bit                            entry_live    [atoe_pkg::TABLE_ENTRIES] = '{default: 1'b0};
   logic [31:0]                   age_counter   = '0;

   stim_row_type      directed_rows [$];
   stim_row_type      pinned_q      [$];
   atoe_pkg::rsp_type expected_q    [$];
   logic [63:0]       key_pool      [12];
   int                mismatch_count = 0;
   int                quiet_cycles   = 0;

   assoc_table_oldest_evict_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // applies one beat to the local copy of the table and returns its result
   function automatic atoe_pkg::rsp_type table_apply(input atoe_pkg::req_type beat);
      logic [atoe_pkg::KEY_BITS-1:0] key;
      int                            hit;
      int                            target;
      atoe_pkg::rsp_type             res;
      key = beat.key_tag[atoe_pkg::KEY_BITS-1:0];
      res = '0;
      hit = -1;
      for (int i = 0; i < atoe_pkg::TABLE_ENTRIES; i++)
         if (hit < 0 && entry_live[i] && stored_key[i] == key)
            hit = i;
      unique case (beat.opcode)
         atoe_pkg::OP_SET: begin
            target = hit;
            if (hit >= 0) begin
               res.found = 1'b1;
            end else begin
               for (int i = 0; i < atoe_pkg::TABLE_ENTRIES; i++)
                  if (target < 0 && !entry_live[i])
                     target = i;
               if (target < 0) begin
                  target = 0;
                  for (int i = 1; i < atoe_pkg::TABLE_ENTRIES; i++)
                     if (entry_age[i] < entry_age[target])
                        target = i;
                  res.evicted = 1'b1;
               end
               stored_key[target] = key;
               entry_live[target] = 1'b1;
            end
            stored_handle[target] = beat.buffer_handle;
            stored_size[target]   = beat.buffer_size;
            entry_age[target]     = age_counter;
            age_counter           = age_counter + 32'd1;
            res.slot              = 3'(target);
         end
         atoe_pkg::OP_FIND: begin
            if (hit >= 0) begin
               res.found        = 1'b1;
               res.slot         = 3'(hit);
               res.found_handle = stored_handle[hit];
               res.found_size   = stored_size[hit];
            end
         end
         atoe_pkg::OP_CLEAR: begin
            if (hit >= 0) begin
               res.found       = 1'b1;
               res.slot        = 3'(hit);
               entry_live[hit] = 1'b0;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      atoe_pkg::rsp_type want;
      atoe_pkg::rsp_type got;
      stim_row_type      row;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               report_mismatch("result beat with nothing pending");
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.found !== want.found)
                  report_mismatch($sformatf("found %b, want %b", rsp_data.found, want.found));
               if (rsp_data.slot !== want.slot)
                  report_mismatch($sformatf("slot %0d, want %0d", rsp_data.slot, want.slot));
               if (rsp_data.evicted !== want.evicted)
                  report_mismatch($sformatf("evicted %b, want %b",
                                            rsp_data.evicted, want.evicted));
               if (rsp_data.found_handle !== want.found_handle)
                  report_mismatch($sformatf("found_handle %h, want %h",
                                            rsp_data.found_handle, want.found_handle));
               if (rsp_data.found_size !== want.found_size)
                  report_mismatch($sformatf("found_size %h, want %h",
                                            rsp_data.found_size, want.found_size));
            end
         end
         if (start && !busy) begin
            got = table_apply(req_data);
            if (pinned_q.size() != 0) begin
               row = pinned_q.pop_front();
               if (row.pinned)
                  got = row.want;
            end
            expected_q.push_back(got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_row(input logic [1:0] op, input logic [63:0] key,
                          input logic [31:0] handle, input logic [31:0] size,
                          input bit pinned, input atoe_pkg::rsp_type want);
      stim_row_type row;
      row.beat   = '{opcode: op, key_tag: key, buffer_handle: handle, buffer_size: size};
      row.pinned = pinned;
      row.want   = want;
      directed_rows.push_back(row);
   endtask

   task automatic send_beat(input stim_row_type row);
      pinned_q.push_back(row);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= row.beat;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic wait_for_results;
      @(negedge clock);
      start <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   function automatic logic [63:0] pick_key;
      int          roll;
      logic [63:0] key;
      roll = $urandom_range(0, 99);
      key  = key_pool[$urandom_range(0, 11)];
      if (roll >= 92)
         key = {$urandom, $urandom};
      else if (roll >= 85)
         key = key ^ (64'd1 << $urandom_range(0, 63));
      return key;
   endfunction

   function automatic atoe_pkg::req_type random_beat;
      int                roll;
      atoe_pkg::req_type beat;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         beat.opcode = atoe_pkg::OP_SET;
      else if (roll < 75)
         beat.opcode = atoe_pkg::OP_FIND;
      else if (roll < 95)
         beat.opcode = atoe_pkg::OP_CLEAR;
      else
         beat.opcode = OP_NONE;
      beat.key_tag       = pick_key();
      beat.buffer_handle = $urandom;
      beat.buffer_size   = $urandom;
      return beat;
   endfunction

   initial begin
      stim_row_type row;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 12; i++)
         key_pool[i] = {$urandom, $urandom};

      // empty table, unused opcode, then fill, update and evict
      add_row(atoe_pkg::OP_FIND,  64'h0, 32'h0, 32'h0, 1, NO_HIT);
      add_row(atoe_pkg::OP_CLEAR, '1, '1, '1, 1, NO_HIT);
      add_row(OP_NONE,            '1, '1, '1, 1, NO_HIT);
      add_row(atoe_pkg::OP_SET,   64'h0, 32'h0, 32'h0, 1, NO_HIT);
      add_row(atoe_pkg::OP_SET,   '1, '1, '1, 1,
              atoe_pkg::rsp_type'{1'b0, 3'd1, 1'b0, 32'h0, 32'h0});
      add_row(atoe_pkg::OP_FIND,  '1, 32'h0, 32'h0, 1,
              atoe_pkg::rsp_type'{1'b1, 3'd1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      add_row(atoe_pkg::OP_FIND,  64'h0, '1, '1, 1,
              atoe_pkg::rsp_type'{1'b1, 3'd0, 1'b0, 32'h0, 32'h0});
      add_row(atoe_pkg::OP_SET,   64'h0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1,
              atoe_pkg::rsp_type'{1'b1, 3'd0, 1'b0, 32'h0, 32'h0});
      add_row(atoe_pkg::OP_FIND,  64'h0, 32'h0, 32'h0, 0, NO_HIT);
      add_row(atoe_pkg::OP_SET,   64'h1, 32'h1, 32'h1, 1,
              atoe_pkg::rsp_type'{1'b0, 3'd2, 1'b0, 32'h0, 32'h0});
      add_row(atoe_pkg::OP_SET,   64'h8000_0000_0000_0000, 32'h8000_0000, 32'h2, 1,
              atoe_pkg::rsp_type'{1'b0, 3'd3, 1'b0, 32'h0, 32'h0});
      add_row(atoe_pkg::OP_SET,   64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h3, 1,
              atoe_pkg::rsp_type'{1'b0, 3'd4, 1'b0, 32'h0, 32'h0});
      add_row(atoe_pkg::OP_SET,   64'hFFFF_FFFF_FFFF_FFFE, 32'hFFFF_FFFE, 32'h4, 1,
              atoe_pkg::rsp_type'{1'b0, 3'd5, 1'b0, 32'h0, 32'h0});
      add_row(atoe_pkg::OP_SET,   64'h2, 32'h2, 32'h5, 1,
              atoe_pkg::rsp_type'{1'b0, 3'd6, 1'b0, 32'h0, 32'h0});
      add_row(atoe_pkg::OP_SET,   64'h3, 32'h3, 32'h6, 1,
              atoe_pkg::rsp_type'{1'b0, 3'd7, 1'b0, 32'h0, 32'h0});
      // table full: oldest entry goes
      add_row(atoe_pkg::OP_SET,   64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF, 32'h100, 0,
              NO_HIT);
      add_row(atoe_pkg::OP_FIND,  '1, 32'h0, 32'h0, 0, NO_HIT);
      add_row(atoe_pkg::OP_CLEAR, 64'h0, 32'h0, 32'h0, 0, NO_HIT);
      add_row(atoe_pkg::OP_CLEAR, 64'h0, 32'h0, 32'h0, 0, NO_HIT);
      add_row(atoe_pkg::OP_SET,   64'hFEDC_BA98_7654_3210, 32'h1234_5678, 32'h40, 0,
              NO_HIT);
      add_row(atoe_pkg::OP_SET,   64'h5555_AAAA_5555_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 0,
              NO_HIT);
      add_row(atoe_pkg::OP_FIND,  64'h0123_4567_89AB_CDEF, 32'h0, 32'h0, 0, NO_HIT);
      add_row(OP_NONE,            64'h0, 32'h0, 32'h0, 1, NO_HIT);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if ($urandom_range(0, 2) == 0)
            hold_off($urandom_range(1, 6));
         send_beat(directed_rows[i]);
      end
      wait_for_results();

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n == RANDOM_BEATS / 2)
            wait_for_results();
         if (n < CALM_FROM && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 6));
         row.beat   = random_beat();
         row.pinned = 1'b0;
         row.want   = '0;
         send_beat(row);
      end
      wait_for_results();
      repeat (20) @(posedge clock);

      if (expected_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/atoe_pkg.sv
design/atoe_ctrl.sv
design/atoe_dpath.sv
design/assoc_table_oldest_evict_unit.sv
design/atoe_checker.sv
verif/assoc_table_oldest_evict_unit_test.sv
